### rtl/etpd_pkg.sv
// Package for the escaped text payload deframer: item types, byte codes and queue sizing.
package etpd_pkg;

  // Framing bytes and length marker bounds
  localparam logic [7:0] Stx         = 8'h02;
  localparam logic [7:0] Etx         = 8'h03;
  localparam logic [7:0] CarRet      = 8'h0D;
  localparam logic [7:0] NlType      = 8'h10;
  localparam logic [7:0] ShortMkEnd  = 8'hD0;
  localparam logic [7:0] LongMkLo    = 8'hF0;
  localparam logic [7:0] LongMkHi    = 8'hFE;

  // Result kinds
  localparam logic [2:0] KindText     = 3'd0;
  localparam logic [2:0] KindStart    = 3'd1;
  localparam logic [2:0] KindBody     = 3'd2;
  localparam logic [2:0] KindEnd      = 3'd3;
  localparam logic [2:0] KindError    = 3'd4;
  localparam logic [2:0] KindAfterErr = 3'd5;

  // Error codes
  localparam logic [1:0] ErrNone      = 2'd0;
  localparam logic [1:0] ErrEarlyEnd  = 2'd1;
  localparam logic [1:0] ErrNoEtx     = 2'd2;
  localparam logic [1:0] ErrBadMarker = 2'd3;

  // Queue between classifier and deframer
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       string_last;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  out_byte;
    logic [7:0]  payload_type;
    logic [31:0] payload_length;
    logic [1:0]  error_code;
    logic        string_end;
  } out_item_t;

  // Classified byte as handed from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
    logic       is_stx;
    logic       is_etx;
    logic       is_nl_type;
    logic       mk_short;
    logic       mk_long;
    logic [3:0] long_mask;
  } cls_t;

endpackage

### rtl/etpd_front.sv
// Front end: accepts input requests and classifies each byte for the deframer.
module etpd_front (
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  etpd_pkg::in_item_t in_item_i,
  input  logic             q_full_i,
  output logic             push_o,
  output etpd_pkg::cls_t   cls_o
);
  import etpd_pkg::*;

  logic [7:0] b;

  assign b          = in_item_i.data_byte;
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    cls_o.data_byte  = b;
    cls_o.last       = in_item_i.string_last;
    cls_o.is_stx     = (b == Stx);
    cls_o.is_etx     = (b == Etx);
    cls_o.is_nl_type = (b == NlType);
    cls_o.mk_short   = (b != 8'h00) && (b < ShortMkEnd);
    cls_o.mk_long    = (b >= LongMkLo) && (b <= LongMkHi);
    // bits 3..0 of marker+1 select length bytes 31:24 .. 7:0
    cls_o.long_mask  = b[3:0] + 4'd1;
  end

endmodule

### rtl/etpd_queue.sv
// Short register queue between the classifier and the deframer.
module etpd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  etpd_pkg::cls_t push_data_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output etpd_pkg::cls_t pop_data_o
);
  import etpd_pkg::*;

  cls_t             mem_q [QDepth];
  logic [QAw-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QAw-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_pop;

  assign full_o     = (cnt_q == QCntW'(QDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QAw'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QAw'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/etpd_back.sv
// Back end: deframing state machine with the registered result output.
module etpd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_data_i,
  input  logic                q_valid_i,
  input  etpd_pkg::cls_t      q_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output etpd_pkg::out_item_t out_item_o
);
  import etpd_pkg::*;

  typedef enum logic [2:0] {
    PhText, PhType, PhMarker, PhLenBytes, PhBody, PhEtx, PhDiscard
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  held_type_q, held_type_d;
  logic [3:0]  len_mask_q, len_mask_d;
  logic [31:0] len_acc_q, len_acc_d;
  logic [31:0] body_rem_q, body_rem_d;
  logic        suppress_q, suppress_d;
  logic        nl_mode_q;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  cls_t        c;
  logic        has_res;
  out_item_t   res;
  logic [31:0] len_done;
  logic        len_fire;
  logic [31:0] acc_or;
  logic [3:0]  mask_clr;
  logic [31:0] rem_dec;

  assign c           = q_data_i;
  assign pop_o       = q_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign rem_dec     = body_rem_q - 32'd1;

  // highest pending length byte first
  always_comb begin
    if (len_mask_q[3]) begin
      acc_or   = {c.data_byte, 24'h0};
      mask_clr = 4'b1000;
    end else if (len_mask_q[2]) begin
      acc_or   = {8'h0, c.data_byte, 16'h0};
      mask_clr = 4'b0100;
    end else if (len_mask_q[1]) begin
      acc_or   = {16'h0, c.data_byte, 8'h0};
      mask_clr = 4'b0010;
    end else begin
      acc_or   = {24'h0, c.data_byte};
      mask_clr = 4'b0001;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    held_type_d = held_type_q;
    len_mask_d  = len_mask_q;
    len_acc_d   = len_acc_q;
    body_rem_d  = body_rem_q;
    suppress_d  = suppress_q;
    has_res     = 1'b0;
    res         = '0;
    len_fire    = 1'b0;
    len_done    = '0;

    case (phase_q)
      PhText: begin
        if (!c.is_stx) begin
          has_res        = 1'b1;
          res.kind       = KindText;
          res.out_byte   = c.data_byte;
          res.string_end = c.last;
        end else if (c.last) begin
          has_res        = 1'b1;
          res.kind       = KindError;
          res.error_code = ErrEarlyEnd;
          res.string_end = 1'b1;
        end else begin
          phase_d = PhType;
        end
      end
      PhType: begin
        if (c.last) begin
          has_res        = 1'b1;
          res.kind       = KindError;
          res.error_code = ErrEarlyEnd;
          res.string_end = 1'b1;
          phase_d        = PhText;
        end else begin
          held_type_d = c.data_byte;
          suppress_d  = nl_mode_q && c.is_nl_type;
          phase_d     = PhMarker;
        end
      end
      PhMarker: begin
        if (!c.mk_short && !c.mk_long) begin
          has_res        = 1'b1;
          res.kind       = KindError;
          res.error_code = ErrBadMarker;
          res.string_end = c.last;
          phase_d        = c.last ? PhText : PhDiscard;
        end else if (c.last) begin
          has_res        = 1'b1;
          res.kind       = KindError;
          res.error_code = ErrEarlyEnd;
          res.string_end = 1'b1;
          phase_d        = PhText;
        end else if (c.mk_short) begin
          len_fire = 1'b1;
          len_done = {24'h0, c.data_byte - 8'd1};
        end else begin
          len_mask_d = c.long_mask;
          len_acc_d  = '0;
          phase_d    = PhLenBytes;
        end
      end
      PhLenBytes: begin
        if (c.last) begin
          has_res        = 1'b1;
          res.kind       = KindError;
          res.error_code = ErrEarlyEnd;
          res.string_end = 1'b1;
          phase_d        = PhText;
        end else begin
          len_acc_d  = len_acc_q | acc_or;
          len_mask_d = len_mask_q & ~mask_clr;
          if ((len_mask_q & ~mask_clr) == 4'h0) begin
            len_fire = 1'b1;
            len_done = len_acc_q | acc_or;
          end
        end
      end
      PhBody: begin
        if (c.last) begin
          has_res        = 1'b1;
          res.kind       = KindError;
          res.error_code = ErrEarlyEnd;
          res.string_end = 1'b1;
          phase_d        = PhText;
        end else begin
          body_rem_d = rem_dec;
          if (rem_dec == 32'h0) begin
            phase_d = PhEtx;
          end
          if (!suppress_q) begin
            has_res          = 1'b1;
            res.kind         = KindBody;
            res.out_byte     = c.data_byte;
            res.payload_type = held_type_q;
          end
        end
      end
      PhEtx: begin
        has_res        = 1'b1;
        res.string_end = c.last;
        if (!c.is_etx) begin
          res.kind       = KindError;
          res.error_code = ErrNoEtx;
          phase_d        = c.last ? PhText : PhDiscard;
        end else if (suppress_q) begin
          res.kind     = KindText;
          res.out_byte = CarRet;
          phase_d      = PhText;
        end else begin
          res.kind         = KindEnd;
          res.payload_type = held_type_q;
          phase_d          = PhText;
        end
      end
      PhDiscard: begin
        if (c.last) begin
          has_res        = 1'b1;
          res.kind       = KindAfterErr;
          res.string_end = 1'b1;
          phase_d        = PhText;
        end
      end
      default: begin
        phase_d = PhText;
      end
    endcase

    if (len_fire) begin
      body_rem_d = len_done;
      phase_d    = (len_done != 32'h0) ? PhBody : PhEtx;
      if (!suppress_q) begin
        has_res            = 1'b1;
        res.kind           = KindStart;
        res.payload_type   = held_type_q;
        res.payload_length = len_done;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (pop_o && has_res) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhText;
      held_type_q <= '0;
      len_mask_q  <= '0;
      len_acc_q   <= '0;
      body_rem_q  <= '0;
      suppress_q  <= 1'b0;
      nl_mode_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        nl_mode_q <= cfg_data_i;
      end
      if (pop_o) begin
        phase_q     <= phase_d;
        held_type_q <= held_type_d;
        len_mask_q  <= len_mask_d;
        len_acc_q   <= len_acc_d;
        body_rem_q  <= body_rem_d;
        suppress_q  <= suppress_d;
      end
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  a_body_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhBody |-> body_rem_q != 32'h0)
    else $error("body phase with zero bytes remaining");

  a_lenbytes_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhLenBytes |-> len_mask_q != 4'h0)
    else $error("length byte phase with empty mask");

  a_last_to_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && c.last |=> phase_q == PhText)
    else $error("final byte did not return to text phase");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && c.last |=> out_valid_q && out_q.string_end)
    else $error("final byte produced no end-marked result");

endmodule

### rtl/escaped_text_payload_deframer_core.sv
// Top level of the escaped text payload deframer: classifier, queue and deframer.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o | in_item_i  (data_byte, string_last)
//   out     | output    | out_valid_o/out_stall_i | out_item_o (kind ... string_end)
//   cfg     | input     | cfg_we_i                | cfg_data_i (newline_mode)
//
// One byte per cycle sustained while the output is not stalled; a byte is written into the queue
// at acceptance, and its result is then registered into the output register by the deframer step.
// The four-entry queue absorbs output stalls; in_stall_o rises only when it is full.
// Reset clears the queue, the output register, the phase and newline_mode.
module escaped_text_payload_deframer_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  etpd_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output etpd_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic                cfg_data_i
);
  import etpd_pkg::*;

  cls_t push_data;
  cls_t pop_data;
  logic push;
  logic pop;
  logic q_full;
  logic q_valid;

  etpd_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cls_o      (push_data)
  );

  etpd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  etpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
